### hdl/frpf_pkg.sv
// ============================================================================
// frpf_pkg
// Shared types and constants for the flooding relay frame filter.
// ============================================================================
package frpf_pkg;

    localparam int ID_W        = 8;
    localparam int SEQ_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [ID_W-1:0] FRAME_BYTES     = 8'd8;
    localparam logic [ID_W-1:0] TYPE_ALERT      = 8'd1;
    localparam logic [ID_W-1:0] MSG_ACK         = 8'd2;
    localparam logic [ID_W-1:0] NODE_ID_RESET   = 8'd3;
    localparam logic [ID_W-1:0] HOP_START_RESET = 8'd2;
    localparam logic [ID_W-1:0] NO_ORIGIN       = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_ID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOP_START = 2'd1;

    typedef enum logic [2:0] {
        ACT_BAD_LEN     = 3'd0,
        ACT_OWN         = 3'd1,
        ACT_DUP         = 3'd2,
        ACT_ACK_RX      = 3'd3,
        ACT_ALERT_ACKED = 3'd4,
        ACT_RELAYED     = 3'd5,
        ACT_EXPIRED     = 3'd6
    } action_t;

    typedef struct packed {
        logic [ID_W-1:0] node_id;
        logic [ID_W-1:0] hop_start;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]  frame_length;
        logic [ID_W-1:0]  rx_type;
        logic [ID_W-1:0]  rx_origin;
        logic [ID_W-1:0]  rx_target;
        logic [ID_W-1:0]  rx_hops;
        logic [SEQ_W-1:0] rx_seq;
    } frame_t;

    typedef struct packed {
        logic             seen_valid;
        logic [ID_W-1:0]  last_origin;
        logic [SEQ_W-1:0] last_seq;
    } seen_t;

    typedef struct packed {
        action_t          action;
        logic             tx_valid;
        logic [ID_W-1:0]  tx_type;
        logic [ID_W-1:0]  tx_origin;
        logic [ID_W-1:0]  tx_target;
        logic [ID_W-1:0]  tx_hops;
        logic [SEQ_W-1:0] tx_seq;
    } result_t;

endpackage

### hdl/frpf_cfg.sv
// ============================================================================
// frpf_cfg
// Configuration registers: node identifier and hop count for answers.
// ============================================================================
module frpf_cfg
    import frpf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_ID:   cfg_next.node_id   = cfg_data;
                REG_HOP_START: cfg_next.hop_start = cfg_data;
                default:       cfg_next = cfg_reg; // ignore unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id   <= NODE_ID_RESET;
            cfg_reg.hop_start <= HOP_START_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/frpf_decide.sv
// ============================================================================
// frpf_decide
// Frame verdict: length, own origin, duplicate checks, then ack/relay/expire.
// ============================================================================
module frpf_decide
    import frpf_pkg::*;
(
    input  cfg_t    cfg,
    input  frame_t  frame,
    input  seen_t   seen,
    output result_t result,
    output logic    record
);

    logic is_dup;
    logic for_me;

    assign is_dup = seen.seen_valid
                 && (frame.rx_origin == seen.last_origin)
                 && (frame.rx_seq == seen.last_seq);
    assign for_me = (frame.rx_target == cfg.node_id);

    always_comb
    begin
        result        = '0;
        result.action = ACT_BAD_LEN;
        record        = 1'b0;
        if (frame.frame_length != FRAME_BYTES)
        begin
            result.action = ACT_BAD_LEN;
        end
        else if (frame.rx_origin == cfg.node_id)
        begin
            result.action = ACT_OWN;
        end
        else if (is_dup)
        begin
            result.action = ACT_DUP;
        end
        else
        begin
            // remember origin and sequence of every frame that gets this far
            record = 1'b1;
            if ((frame.rx_type == MSG_ACK) && for_me)
            begin
                result.action = ACT_ACK_RX;
            end
            else if ((frame.rx_type == TYPE_ALERT) && for_me)
            begin
                result.action    = ACT_ALERT_ACKED;
                result.tx_valid  = 1'b1;
                result.tx_type   = MSG_ACK;
                result.tx_origin = cfg.node_id;
                result.tx_target = frame.rx_origin;
                result.tx_hops   = cfg.hop_start;
                result.tx_seq    = frame.rx_seq;
            end
            else if (frame.rx_hops == '0)
            begin
                result.action = ACT_EXPIRED;
            end
            else
            begin
                result.action    = ACT_RELAYED;
                result.tx_valid  = 1'b1;
                result.tx_type   = frame.rx_type;
                result.tx_origin = frame.rx_origin;
                result.tx_target = frame.rx_target;
                result.tx_hops   = frame.rx_hops - 8'd1;
                result.tx_seq    = frame.rx_seq;
            end
        end
    end

endmodule

### hdl/flood_relay_packet_filter.sv
// ============================================================================
// flood_relay_packet_filter
// Flooding relay front end: drops bad, own, duplicate and expired frames,
// answers alerts and takes acks addressed here; relays the rest, one hop fewer.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one received frame header per
//   transaction. Output channel (out_valid / out_stall) returns exactly one
//   verdict per frame: the action code and, when tx_valid is high, the frame
//   to broadcast (otherwise the tx fields read zero).
//   A frame taken into the input register has its verdict loaded into the
//   result register once that register is free or draining, and presented
//   from then on. Throughput: one frame every cycle while out_stall is low;
//   the only dependency between frames is the last-seen origin and sequence,
//   updated as the verdict is registered, so the next frame checks against it.
//   Reset clears both pipeline stages, the duplicate memory (nothing seen)
//   and loads node_id 3 and hop_start 2.
//   When the receiver stalls, the result register holds; the input register
//   still fills, and in_stall rises only once both stages are occupied.
//   Write configuration through cfg_we / cfg_index / cfg_data while idle;
//   unknown indexes are ignored.
// ============================================================================
module flood_relay_packet_filter
    import frpf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // received frame
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ID_W-1:0]        frame_length,
    input  logic [ID_W-1:0]        rx_type,
    input  logic [ID_W-1:0]        rx_origin,
    input  logic [ID_W-1:0]        rx_target,
    input  logic [ID_W-1:0]        rx_hops,
    input  logic [SEQ_W-1:0]       rx_seq,
    // verdict and outgoing frame
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             action,
    output logic                   tx_valid,
    output logic [ID_W-1:0]        tx_type,
    output logic [ID_W-1:0]        tx_origin,
    output logic [ID_W-1:0]        tx_target,
    output logic [ID_W-1:0]        tx_hops,
    output logic [SEQ_W-1:0]       tx_seq
);

    cfg_t    cfg;
    frame_t  in_frame_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t out_result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    seen_t   seen_reg;
    seen_t   seen_next;
    result_t verdict;
    logic    record;
    logic    accept;
    logic    advance;

    frpf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frpf_decide u_decide (
        .cfg    (cfg),
        .frame  (in_frame_reg),
        .seen   (seen_reg),
        .result (verdict),
        .record (record)
    );

    // Advance the held frame whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Update the duplicate memory only as the verdict is committed.
        seen_next = seen_reg;
        if (advance && record)
        begin
            seen_next.seen_valid  = 1'b1;
            seen_next.last_origin = in_frame_reg.rx_origin;
            seen_next.last_seq    = in_frame_reg.rx_seq;
        end
    end

    // Control state and duplicate memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            seen_reg.seen_valid  <= 1'b0;
            seen_reg.last_origin <= NO_ORIGIN;
            seen_reg.last_seq    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
        end
    end

    // Payload registers: load the input on a transaction, the verdict on advance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_frame_reg.frame_length <= frame_length;
            in_frame_reg.rx_type      <= rx_type;
            in_frame_reg.rx_origin    <= rx_origin;
            in_frame_reg.rx_target    <= rx_target;
            in_frame_reg.rx_hops      <= rx_hops;
            in_frame_reg.rx_seq       <= rx_seq;
        end
        if (advance)
        begin
            out_result_reg <= verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = out_result_reg.action;
    assign tx_valid  = out_result_reg.tx_valid;
    assign tx_type   = out_result_reg.tx_type;
    assign tx_origin = out_result_reg.tx_origin;
    assign tx_target = out_result_reg.tx_target;
    assign tx_hops   = out_result_reg.tx_hops;
    assign tx_seq    = out_result_reg.tx_seq;

endmodule
